// ----- rtl/urd_pkg.sv -----
package urd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RUNE_W  = 21;
  localparam int unsigned ACC_W   = 31;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 3;

  // Default depth of the result queue; two slots are written per input item at most.
  localparam int unsigned RESULT_DEPTH = 4;

  localparam logic [RUNE_W-1:0] RUNE_ERROR = 21'h00FFFD;
  localparam logic [ACC_W-1:0]  RUNE_MAX   = 31'h0010FFFF;
  localparam logic [ACC_W-1:0]  SURR_LO    = 31'h0000D800;
  localparam logic [ACC_W-1:0]  SURR_HI    = 31'h0000DFFF;
  localparam logic [ACC_W-1:0]  NONCH_LO   = 31'h0000FDD0;
  localparam logic [ACC_W-1:0]  NONCH_HI   = 31'h0000FDEF;

  typedef enum logic [STAT_W-1:0] {
    ST_VALID     = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [RUNE_W-1:0]  code_point;
    status_e            status;
    logic [COUNT_W-1:0] byte_count;
    logic               last_of_run;
  } res_t;

  // Up to two results leave the decoder per item.
  typedef struct packed {
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
  } push_t;

  function automatic res_t mk_res(logic [RUNE_W-1:0] cp, status_e st,
                                  logic [COUNT_W-1:0] cnt);
    res_t r;
    r.code_point  = cp;
    r.status      = st;
    r.byte_count  = cnt;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Sequence length from the low six bits of a lead byte (11xxxxxx); 0 = illegal.
  function automatic logic [COUNT_W-1:0] lead_length(logic [5:0] low);
    logic [COUNT_W-1:0] n;
    case (low) inside
      [6'd0:6'd1]:   n = 3'd0;
      [6'd2:6'd31]:  n = 3'd2;
      [6'd32:6'd47]: n = 3'd3;
      [6'd48:6'd55]: n = 3'd4;
      [6'd56:6'd59]: n = 3'd5;
      [6'd60:6'd61]: n = 3'd6;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  // Payload bits kept from the lead byte: (1 << (8 - length)) - 1, limited to six bits.
  function automatic logic [5:0] lead_mask(logic [COUNT_W-1:0] n);
    logic [5:0] m;
    case (n)
      3'd2:    m = 6'h3F;
      3'd3:    m = 6'h1F;
      3'd4:    m = 6'h0F;
      3'd5:    m = 6'h07;
      3'd6:    m = 6'h03;
      default: m = 6'h00;
    endcase
    return m;
  endfunction

  function automatic logic rune_ok(logic [ACC_W-1:0] r);
    logic ok;
    ok = 1'b1;
    if (r >= SURR_LO && r <= SURR_HI) ok = 1'b0;
    if (r >= NONCH_LO && r <= NONCH_HI) ok = 1'b0;
    if (r[15:1] == 15'h7FFF) ok = 1'b0;
    if (r > RUNE_MAX) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ----- rtl/urd_if.sv -----
interface urd_in_if;
  import urd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface urd_out_if;
  import urd_pkg::*;

  logic               valid;
  logic               ready;
  logic [RUNE_W-1:0]  code_point;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] byte_count;
  logic               last_of_run;

  modport source (output valid, code_point, status, byte_count, last_of_run, input ready);
  modport sink   (input valid, code_point, status, byte_count, last_of_run, output ready);
endinterface

// ----- rtl/urd_decode.sv -----
module urd_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  urd_in_if.sink         in_i,
  input  logic           space_ok_i,
  output urd_pkg::push_t push_o
);
  import urd_pkg::*;

  // Input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic              eoi_q;

  // Open sequence
  logic [COUNT_W-1:0] exp_q, exp_d;
  logic [COUNT_W-1:0] seen_q, seen_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [2:0]         lmb_q, lmb_d;

  logic consume;

  assign consume     = in_valid_q && space_ok_i;
  assign in_i.ready  = !in_valid_q || space_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
      eoi_q  <= in_i.end_of_input;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= '0;
      seen_q <= '0;
      acc_q  <= '0;
      lmb_q  <= '0;
    end else if (consume) begin
      exp_q  <= exp_d;
      seen_q <= seen_d;
      acc_q  <= acc_d;
      lmb_q  <= lmb_d;
    end
  end

  logic               open_seq;
  logic               f_emit;
  res_t               f_res;
  logic [COUNT_W-1:0] f_len;
  logic               brk_emit, main_emit, trunc_emit;
  res_t               brk_res, main_res, trunc_res;
  logic [ACC_W-1:0]   acc_n;
  logic [COUNT_W-1:0] seen_n;
  res_t               r0, r1;
  logic               p0, p1;

  always_comb begin
    open_seq = (exp_q inside {[3'd2:3'd6]});

    // Decode the byte as if no sequence were open
    f_len  = lead_length(byte_q[5:0]);
    f_emit = 1'b1;
    if (!byte_q[7]) begin
      f_res = mk_res(RUNE_W'(byte_q), ST_VALID, 3'd1);
    end else if (!byte_q[6] || f_len == 3'd0) begin
      f_res = mk_res(RUNE_ERROR, ST_MALFORMED, 3'd1);
    end else begin
      f_emit = 1'b0;
      f_res  = mk_res(RUNE_ERROR, ST_MALFORMED, 3'd1);
    end

    brk_emit  = 1'b0;
    brk_res   = mk_res(RUNE_ERROR, ST_MALFORMED, seen_q);
    main_emit = 1'b0;
    main_res  = f_res;
    acc_n     = {acc_q[ACC_W-7:0], byte_q[5:0]};
    seen_n    = seen_q + 3'd1;
    exp_d     = exp_q;
    seen_d    = seen_q;
    acc_d     = acc_q;
    lmb_d     = lmb_q;

    if (!open_seq || byte_q[7:6] != 2'b10) begin
      // Nothing to continue: close any open error rune, then redo this byte
      brk_emit  = open_seq;
      main_emit = f_emit;
      main_res  = f_res;
      if (!f_emit) begin
        exp_d  = f_len;
        seen_d = 3'd1;
        lmb_d  = 3'(4'd8 - {1'b0, f_len});
        acc_d  = ACC_W'(byte_q[5:0] & lead_mask(f_len));
      end else begin
        exp_d  = '0;
        seen_d = '0;
        acc_d  = '0;
        lmb_d  = '0;
      end
    end else begin
      acc_d  = acc_n;
      seen_d = seen_n;
      if (seen_n == 3'd2 && (acc_n >> lmb_q) == '0) begin
        main_emit = 1'b1;
        main_res  = mk_res(RUNE_ERROR, ST_MALFORMED, 3'd2);
      end else if (seen_n >= exp_q) begin
        main_emit = 1'b1;
        if (rune_ok(acc_n)) begin
          main_res = mk_res(acc_n[RUNE_W-1:0], ST_VALID, exp_q);
        end else begin
          main_res = mk_res(RUNE_ERROR, ST_MALFORMED, exp_q);
        end
      end
      if (main_emit) begin
        exp_d  = '0;
        seen_d = '0;
        acc_d  = '0;
        lmb_d  = '0;
      end
    end

    // Flush a sequence still open at end of input
    trunc_emit = eoi_q && exp_d != '0;
    trunc_res  = mk_res(RUNE_ERROR, ST_TRUNCATED, seen_d);
    if (trunc_emit) begin
      exp_d  = '0;
      seen_d = '0;
      acc_d  = '0;
      lmb_d  = '0;
    end

    // Pack the (at most two) results in order
    p0 = brk_emit || main_emit || trunc_emit;
    if (brk_emit) begin
      r0 = brk_res;
    end else if (main_emit) begin
      r0 = main_res;
    end else begin
      r0 = trunc_res;
    end
    p1 = 1'b0;
    r1 = trunc_res;
    if (brk_emit) begin
      p1 = main_emit || trunc_emit;
      r1 = main_emit ? main_res : trunc_res;
    end else if (main_emit) begin
      p1 = trunc_emit;
    end
    r0.last_of_run = !p1;
    r1.last_of_run = 1'b1;

    push_o.push0 = consume && p0;
    push_o.push1 = consume && p1;
    push_o.res0  = r0;
    push_o.res1  = r1;
  end

endmodule

// ----- rtl/urd_result_fifo.sv -----
module urd_result_fifo #(
  parameter int unsigned Depth = urd_pkg::RESULT_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  urd_pkg::push_t push_i,
  urd_out_if.source      out_o,
  output logic           space_ok_o
);
  import urd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr1;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop        = out_o.valid && out_o.ready;
  assign space_ok_o = cnt_q <= CntW'(Depth - 2);
  assign wr1        = ptr_inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q - CntW'(pop);
    if (push_i.push0 && push_i.push1) begin
      wr_d  = ptr_inc(wr1);
      cnt_d = cnt_d + CntW'(2);
    end else if (push_i.push0) begin
      wr_d  = wr1;
      cnt_d = cnt_d + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr1] <= push_i.res1;
    end
  end

  assign out_o.valid       = cnt_q != '0;
  assign out_o.code_point  = mem_q[rd_q].code_point;
  assign out_o.status      = mem_q[rd_q].status;
  assign out_o.byte_count  = mem_q[rd_q].byte_count;
  assign out_o.last_of_run = mem_q[rd_q].last_of_run;

endmodule

// ----- rtl/utf8_rune_decoder_unit.sv -----
// A byte accepted at the input passes the input register and then the result queue
//   register before its first result appears on the output.
// Throughput: one byte per cycle while each byte yields at most one result and out_o is
//   not stalled; a byte's two results leave one at a time via the single output port.
// Reset: asynchronous, active low; clears any open sequence and empties the result queue.
module utf8_rune_decoder_unit #(
  parameter int unsigned ResultDepth = urd_pkg::RESULT_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  urd_in_if.sink    in_i,
  urd_out_if.source out_o
);
  import urd_pkg::*;

  // Decoder pushes up to two results per consumed byte; the queue only lets it
  // consume a byte while two free slots are guaranteed, so nothing is ever dropped.
  push_t push;
  logic  space_ok;

  // Input register, sequence state and per-byte decode.
  urd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  // Result queue: parts the output handshake from the input side and absorbs the second result
  // of a byte that breaks an open sequence.
  urd_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .out_o      (out_o),
    .space_ok_o (space_ok)
  );

endmodule

// ----- rtl/urd_checker.sv -----
module urd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [urd_pkg::RUNE_W-1:0]  code_point_i,
  input logic [urd_pkg::STAT_W-1:0]  status_i,
  input logic [urd_pkg::COUNT_W-1:0] byte_count_i,
  input logic                        last_of_run_i
);
  import urd_pkg::*;

  // Hold a stalled transaction unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_point_i) &&
      $stable(status_i) && $stable(byte_count_i) && $stable(last_of_run_i))
    else $error("result changed while stalled");

  // Any error or truncation carries the replacement rune.
  a_err_rune: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_VALID |-> code_point_i == RUNE_ERROR)
    else $error("error result without replacement rune");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_count_i >= 3'd1 && byte_count_i <= 3'd6)
    else $error("byte count out of range");

  // A valid single-byte rune is plain ASCII.
  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_VALID && byte_count_i == 3'd1 |->
      code_point_i < 21'h80)
    else $error("single-byte rune above ASCII");

  a_max_rune: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> code_point_i <= 21'h10FFFF && status_i != 2'd3)
    else $error("rune or status out of range");

endmodule

bind utf8_rune_decoder_unit urd_checker u_urd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .code_point_i  (out_o.code_point),
  .status_i      (out_o.status),
  .byte_count_i  (out_o.byte_count),
  .last_of_run_i (out_o.last_of_run)
);
